[rtl/rwc_pkg.sv]
// ----------------------------------------------------------------------------
// rwc_pkg: shared types and constants of the rgb window convolution
// word formats, kernel geometry, register indexes and lane control
// ----------------------------------------------------------------------------
`default_nettype none

package rwc_pkg;

  localparam int KERNEL_SIZE  = 5;
  localparam int KHALF        = KERNEL_SIZE / 2;
  localparam int KTAPS        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int TAP_W        = 5;
  localparam int PIXEL_BITS   = 16;
  localparam int COEF_BITS    = 16;
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int CFG_W_BITS   = 11;
  localparam int CFG_H_BITS   = 13;
  localparam int ROW_BITS     = 13;
  localparam int OUT_ROW_BITS = 12;
  localparam int OUT_COL_BITS = 10;
  localparam int FUNC_BITS    = 2;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PIXEL = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_e;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [COEF_BITS-1:0]  coef_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_t;

  typedef struct packed {
    coef_t red;
    coef_t green;
    coef_t blue;
  } rgb_coef_t;

  typedef struct packed {
    logic                    adv;
    logic                    shift;
    logic                    load;
    logic [TAP_W-1:0]        tap;
    logic [KERNEL_SIZE-1:0]  row_ok;
    logic [KERNEL_SIZE-1:0]  col_ok;
  } lane_ctl_t;

  typedef struct packed {
    logic [OUT_ROW_BITS-1:0] row;
    logic [OUT_COL_BITS-1:0] col;
    logic                    last;
  } pos_t;

endpackage

`default_nettype wire

[rtl/rwc_if.sv]
// ----------------------------------------------------------------------------
// rwc_if: stream channels of the rgb window convolution
// input word channel and result word channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface rwc_in_if;
  logic                                valid;
  logic                                ready;
  logic [rwc_pkg::FUNC_BITS-1:0]       func;
  logic [rwc_pkg::TAP_W-1:0]           tap_index;
  logic [rwc_pkg::PIXEL_BITS-1:0]      pix_red;
  logic [rwc_pkg::PIXEL_BITS-1:0]      pix_green;
  logic [rwc_pkg::PIXEL_BITS-1:0]      pix_blue;
  logic [rwc_pkg::COEF_BITS-1:0]       coef_red;
  logic [rwc_pkg::COEF_BITS-1:0]       coef_green;
  logic [rwc_pkg::COEF_BITS-1:0]       coef_blue;

  modport source (output valid, func, tap_index, pix_red, pix_green, pix_blue,
                  coef_red, coef_green, coef_blue, input ready);
  modport sink (input valid, func, tap_index, pix_red, pix_green, pix_blue,
                coef_red, coef_green, coef_blue, output ready);
endinterface

interface rwc_out_if;
  logic                                valid;
  logic                                ready;
  logic [rwc_pkg::PIXEL_BITS-1:0]      out_red;
  logic [rwc_pkg::PIXEL_BITS-1:0]      out_green;
  logic [rwc_pkg::PIXEL_BITS-1:0]      out_blue;
  logic [rwc_pkg::OUT_ROW_BITS-1:0]    out_row;
  logic [rwc_pkg::OUT_COL_BITS-1:0]    out_col;
  logic                                last_of_frame;

  modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                  last_of_frame, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_row, out_col,
                last_of_frame, output ready);
endinterface

`default_nettype wire

[rtl/rwc_line_buf.sv]
// ----------------------------------------------------------------------------
// rwc_line_buf: line memory indexed by column
// one write and one registered read per cycle, write-to-read bypass
// ----------------------------------------------------------------------------
`default_nettype none

module rwc_line_buf #(
  parameter int DEPTH  = rwc_pkg::MAX_WIDTH,
  parameter int WORD_W = 192
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WORD_W-1:0]        wr_data_i,
  output      logic [WORD_W-1:0]        rd_data_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // same address in the same cycle only for one-pixel rows
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

[rtl/rwc_lane.sv]
// ----------------------------------------------------------------------------
// rwc_lane: one color channel of the convolution
// window registers, kernel taps, products, row sums, total, round and clip
// ----------------------------------------------------------------------------
`default_nettype none

module rwc_lane (
  input  wire logic                                                      clk_i,
  input  wire rwc_pkg::lane_ctl_t                                        ctl_i,
  input  wire logic [rwc_pkg::KERNEL_SIZE-1:0][rwc_pkg::PIXEL_BITS-1:0] col_i,
  input  wire rwc_pkg::coef_t                                            coef_i,
  output      rwc_pkg::pix_t                                             res_o
);

  localparam int K      = rwc_pkg::KERNEL_SIZE;
  localparam int PB     = rwc_pkg::PIXEL_BITS;
  localparam int CB     = rwc_pkg::COEF_BITS;
  localparam int PROD_W = PB + CB;
  localparam int SUM_W  = PROD_W + $clog2(K);
  localparam int ACC_W  = SUM_W + $clog2(K);

  logic [K-1:0][K-1:0][PB-1:0] win_q;
  rwc_pkg::coef_t              kern_q [rwc_pkg::KTAPS];
  logic [PROD_W-1:0]           prod_q [K][K];
  logic [SUM_W-1:0]            row_d  [K];
  logic [SUM_W-1:0]            row_q  [K];
  logic [ACC_W-1:0]            tot_d;
  logic [ACC_W-1:0]            tot_q;
  logic [ACC_W-1:0]            rnd;
  rwc_pkg::pix_t               res_d;
  rwc_pkg::pix_t               res_q;

  always_comb begin
    for (int m = 0; m < K; m++) begin
      row_d[m] = '0;
      for (int n = 0; n < K; n++) begin
        row_d[m] = row_d[m] + SUM_W'(prod_q[m][n]);
      end
    end
    tot_d = '0;
    for (int m = 0; m < K; m++) begin
      tot_d = tot_d + ACC_W'(row_q[m]);
    end
  end

  // round half up to pixel scale, clip at full scale
  always_comb begin
    rnd = tot_q + {{(ACC_W-CB){1'b0}}, 1'b1, {(CB-1){1'b0}}};
    if (|rnd[ACC_W-1:CB+PB]) begin
      res_d = '1;
    end else begin
      res_d = rnd[CB+PB-1:CB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      if (ctl_i.shift) begin
        for (int i = 0; i < K; i++) begin
          win_q[i] <= {win_q[i][K-2:0], col_i[i]};
        end
      end
      if (ctl_i.load && (32'(ctl_i.tap) < rwc_pkg::KTAPS)) begin
        kern_q[ctl_i.tap] <= coef_i;
      end
      for (int m = 0; m < K; m++) begin
        for (int n = 0; n < K; n++) begin
          if (ctl_i.row_ok[m] && ctl_i.col_ok[n]) begin
            prod_q[m][n] <= PROD_W'(win_q[K-1-m][K-1-n]) * PROD_W'(kern_q[m*K+n]);
          end else begin
            prod_q[m][n] <= '0;
          end
        end
      end
      for (int m = 0; m < K; m++) begin
        row_q[m] <= row_d[m];
      end
      tot_q <= tot_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[rtl/rwc_merge.sv]
// ----------------------------------------------------------------------------
// rwc_merge: joins the lane results with the position into a result word
// output register with one skid entry, drives the pipeline advance
// ----------------------------------------------------------------------------
`default_nettype none

module rwc_merge (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fin_valid_i,
  input  wire rwc_pkg::rgb_t res_i,
  input  wire rwc_pkg::pos_t pos_i,
  output      logic          adv_o,
  rwc_out_if.source          out_o
);

  typedef struct packed {
    rwc_pkg::rgb_t rgb;
    rwc_pkg::pos_t pos;
  } word_t;

  logic  out_v_q;
  logic  skid_v_q;
  word_t out_w_q;
  word_t skid_w_q;
  word_t fin_w;
  logic  take;
  logic  fill;
  logic  out_free;

  assign fin_w    = '{rgb: res_i, pos: pos_i};
  assign take     = out_v_q && out_o.ready;
  assign fill     = fin_valid_i && !skid_v_q;
  assign out_free = !out_v_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (out_free) begin
      out_v_q <= fill;
    end else if (fill) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_w_q <= skid_w_q;
      end
    end else if (out_free) begin
      out_w_q <= fin_w;
    end else begin
      skid_w_q <= fin_w;
    end
  end

  assign adv_o               = !skid_v_q;
  assign out_o.valid         = out_v_q;
  assign out_o.out_red       = out_w_q.rgb.red;
  assign out_o.out_green     = out_w_q.rgb.green;
  assign out_o.out_blue      = out_w_q.rgb.blue;
  assign out_o.out_row       = out_w_q.pos.row;
  assign out_o.out_col       = out_w_q.pos.col;
  assign out_o.last_of_frame = out_w_q.pos.last;

endmodule

`default_nettype wire

[rtl/rgb_window_convolution_5x5_top.sv]
// ----------------------------------------------------------------------------
// rgb_window_convolution_5x5_top: streaming 5x5 rgb convolution
// zero-padded window filter with per-channel kernels and apb setup
// ----------------------------------------------------------------------------
// The block takes one input word per clock and sustains that rate; the only
// time in ready drops is when the result side has held off long enough to fill
// the one-word skid behind the output register. A pixel or flush word at frame
// position k produces the result for position k - (2*width + 2) once that
// lies in the frame, so the last two rows plus two pixels are drained with
// flush words. After the word that produced it is accepted, a result passes
// through the memory read, window shift, products, row sums, total, round and
// clip and output register in that order. The line memory holds MAX_WIDTH
// columns of four previous rows and is read and rewritten once per pixel
// or flush word; it needs no clearing, since taps outside the frame are
// masked to zero. Kernel load words travel down the same pipeline and update
// the taps in order with the pixel words around them. Writing either size
// register restarts the frame; write them only while the block is idle.
`default_nettype none

module rgb_window_convolution_5x5_top #(
  parameter int MAX_WIDTH = rwc_pkg::MAX_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rwc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [rwc_pkg::APB_DW-1:0]   pwdata,
  output      logic [rwc_pkg::APB_DW-1:0]   prdata,
  output      logic                         pready,
  rwc_in_if.sink                            in_i,
  rwc_out_if.source                         out_o
);

  localparam int K       = rwc_pkg::KERNEL_SIZE;
  localparam int KH      = rwc_pkg::KHALF;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int W_W     = COL_W + 1;
  localparam int RB      = rwc_pkg::ROW_BITS;
  localparam int HB      = rwc_pkg::CFG_H_BITS;
  localparam int LINE_W  = (K - 1) * $bits(rwc_pkg::rgb_t);
  localparam int LANE_LAT = 4;

  // ---------------------------------------------------------------- config
  logic [rwc_pkg::CFG_W_BITS-1:0] cfg_w_q;
  logic [HB-1:0]                  cfg_h_q;
  logic                           cfg_wr;
  logic [W_W-1:0]                 eff_w;
  logic [HB-1:0]                  eff_h;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= rwc_pkg::CFG_W_BITS'(rwc_pkg::WIDTH_RESET);
      cfg_h_q <= HB'(rwc_pkg::HEIGHT_RESET);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rwc_pkg::REG_WIDTH:  cfg_w_q <= pwdata[rwc_pkg::CFG_W_BITS-1:0];
        rwc_pkg::REG_HEIGHT: cfg_h_q <= pwdata[HB-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rwc_pkg::REG_WIDTH:  prdata = rwc_pkg::APB_DW'(cfg_w_q);
      rwc_pkg::REG_HEIGHT: prdata = rwc_pkg::APB_DW'(cfg_h_q);
    endcase
  end

  // out-of-range sizes act as the nearest legal size
  always_comb begin
    priority if (cfg_w_q == '0) begin
      eff_w = W_W'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      eff_w = W_W'(MAX_WIDTH);
    end else begin
      eff_w = W_W'(cfg_w_q);
    end
    priority if (cfg_h_q == '0) begin
      eff_h = HB'(1);
    end else if (32'(cfg_h_q) > rwc_pkg::MAX_HEIGHT) begin
      eff_h = HB'(rwc_pkg::MAX_HEIGHT);
    end else begin
      eff_h = cfg_h_q;
    end
  end

  // ---------------------------------------------------------- input stage
  logic               adv;
  logic               acc;
  rwc_pkg::func_e     func;
  logic               is_pos;
  logic               is_load;
  logic               step;
  logic [COL_W-1:0]   in_col_q;
  logic [RB-1:0]      in_row_q;
  logic [COL_W-1:0]   out_c_q;
  logic [RB-1:0]      out_r_q;
  logic               col_wrap;
  logic               ocol_wrap;
  logic               primed;
  logic               beyond;
  logic               last;
  logic               emit;
  logic               restart;

  assign in_i.ready = adv;
  assign acc        = in_i.valid && adv;
  assign func       = rwc_pkg::func_e'(in_i.func);

  always_comb begin
    is_pos  = 1'b0;
    is_load = 1'b0;
    unique case (func)
      rwc_pkg::FUNC_LOAD:  is_load = 1'b1;
      rwc_pkg::FUNC_PIXEL,
      rwc_pkg::FUNC_FLUSH: is_pos  = 1'b1;
      default: ;
    endcase
  end

  assign step      = acc && is_pos;
  assign col_wrap  = (W_W'(in_col_q) + W_W'(1)) >= eff_w;
  assign ocol_wrap = (W_W'(out_c_q) + W_W'(1)) >= eff_w;

  // enough words seen for the window center to trail by two rows, two columns
  always_comb begin
    if (eff_w == W_W'(1)) begin
      primed = in_row_q >= RB'(2 * KH);
    end else begin
      primed = (in_row_q > RB'(KH)) || ((in_row_q == RB'(KH)) && (in_col_q >= COL_W'(KH)));
    end
  end

  assign beyond  = out_r_q >= RB'(eff_h);
  assign last    = (out_r_q == RB'(eff_h - HB'(1))) && (W_W'(out_c_q) == eff_w - W_W'(1));
  assign emit    = step && primed && !beyond;
  assign restart = step && primed && (beyond || last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      out_c_q  <= '0;
      out_r_q  <= '0;
    end else if (cfg_wr || restart) begin
      in_col_q <= '0;
      in_row_q <= '0;
      out_c_q  <= '0;
      out_r_q  <= '0;
    end else if (step) begin
      if (col_wrap) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + RB'(1);
      end else begin
        in_col_q <= in_col_q + COL_W'(1);
      end
      if (emit) begin
        if (ocol_wrap) begin
          out_c_q <= '0;
          out_r_q <= out_r_q + RB'(1);
        end else begin
          out_c_q <= out_c_q + COL_W'(1);
        end
      end
    end
  end

  // ------------------------------------------------- stage 1: line memory
  logic                      s1_pos_q;
  logic                      s1_load_q;
  logic                      s1_emit_q;
  logic [rwc_pkg::TAP_W-1:0] s1_tap_q;
  rwc_pkg::rgb_coef_t        s1_coef_q;
  rwc_pkg::rgb_t             s1_pix_q;
  logic [COL_W-1:0]          s1_col_q;
  logic [COL_W-1:0]          s1_c_q;
  logic [RB-1:0]             s1_r_q;
  logic                      s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_pos_q  <= 1'b0;
      s1_load_q <= 1'b0;
      s1_emit_q <= 1'b0;
    end else if (adv) begin
      s1_pos_q  <= step;
      s1_load_q <= acc && is_load;
      s1_emit_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_tap_q  <= in_i.tap_index;
      s1_coef_q <= '{red: in_i.coef_red, green: in_i.coef_green, blue: in_i.coef_blue};
      if (func == rwc_pkg::FUNC_PIXEL) begin
        s1_pix_q <= '{red: in_i.pix_red, green: in_i.pix_green, blue: in_i.pix_blue};
      end else begin
        s1_pix_q <= '0;
      end
      s1_col_q  <= in_col_q;
      s1_c_q    <= out_c_q;
      s1_r_q    <= out_r_q;
      s1_last_q <= last;
    end
  end

  rwc_pkg::rgb_t [K-2:0] line_rd;
  rwc_pkg::rgb_t [K-2:0] line_wr;
  rwc_pkg::rgb_t [K-1:0] col_vec;

  // newest pixel on top, the stored rows below it
  always_comb begin
    col_vec[0] = s1_pix_q;
    for (int i = 1; i < K; i++) begin
      col_vec[i] = line_rd[i-1];
    end
    for (int i = 0; i < K - 1; i++) begin
      line_wr[i] = col_vec[i];
    end
  end

  rwc_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .WORD_W (LINE_W)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (step),
    .rd_addr_i (in_col_q),
    .wr_en_i   (adv && s1_pos_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (line_wr),
    .rd_data_o (line_rd)
  );

  // frame-edge masks for the result position
  logic [K-1:0] row_ok;
  logic [K-1:0] col_ok;
  logic signed [RB+1:0]    rr;
  logic signed [COL_W+1:0] cc;

  always_comb begin
    rr = '0;
    cc = '0;
    for (int m = 0; m < K; m++) begin
      rr        = $signed({2'b00, s1_r_q}) + (RB+2)'(m - KH);
      row_ok[m] = (rr >= 0) && (rr < $signed({2'b00, eff_h}));
    end
    for (int n = 0; n < K; n++) begin
      cc        = $signed({2'b00, s1_c_q}) + (COL_W+2)'(n - KH);
      col_ok[n] = (cc >= 0) && (cc < $signed({1'b0, eff_w}));
    end
  end

  // ------------------------------------------------ stage 2: window ready
  logic                      s2_load_q;
  logic                      s2_emit_q;
  logic [rwc_pkg::TAP_W-1:0] s2_tap_q;
  rwc_pkg::rgb_coef_t        s2_coef_q;
  logic [K-1:0]              s2_rok_q;
  logic [K-1:0]              s2_cok_q;
  rwc_pkg::pos_t             s2_at_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_load_q <= 1'b0;
      s2_emit_q <= 1'b0;
    end else if (adv) begin
      s2_load_q <= s1_load_q;
      s2_emit_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_tap_q  <= s1_tap_q;
      s2_coef_q <= s1_coef_q;
      s2_rok_q  <= row_ok;
      s2_cok_q  <= col_ok;
      s2_at_q   <= '{row:  s1_r_q[rwc_pkg::OUT_ROW_BITS-1:0],
                     col:  rwc_pkg::OUT_COL_BITS'(s1_c_q),
                     last: s1_last_q};
    end
  end

  // ---------------------------------------------------------------- lanes
  rwc_pkg::lane_ctl_t lane_ctl;
  rwc_pkg::rgb_t      lane_res;
  logic [K-1:0][rwc_pkg::PIXEL_BITS-1:0] col_red;
  logic [K-1:0][rwc_pkg::PIXEL_BITS-1:0] col_green;
  logic [K-1:0][rwc_pkg::PIXEL_BITS-1:0] col_blue;

  always_comb begin
    for (int i = 0; i < K; i++) begin
      col_red[i]   = col_vec[i].red;
      col_green[i] = col_vec[i].green;
      col_blue[i]  = col_vec[i].blue;
    end
  end

  // window shifts with the stage-1 word, taps load with the stage-2 word
  assign lane_ctl = '{adv:    adv,
                      shift:  s1_pos_q,
                      load:   s2_load_q,
                      tap:    s2_tap_q,
                      row_ok: s2_rok_q,
                      col_ok: s2_cok_q};

  rwc_lane u_lane_red (
    .clk_i  (clk_i),
    .ctl_i  (lane_ctl),
    .col_i  (col_red),
    .coef_i (s2_coef_q.red),
    .res_o  (lane_res.red)
  );

  rwc_lane u_lane_green (
    .clk_i  (clk_i),
    .ctl_i  (lane_ctl),
    .col_i  (col_green),
    .coef_i (s2_coef_q.green),
    .res_o  (lane_res.green)
  );

  rwc_lane u_lane_blue (
    .clk_i  (clk_i),
    .ctl_i  (lane_ctl),
    .col_i  (col_blue),
    .coef_i (s2_coef_q.blue),
    .res_o  (lane_res.blue)
  );

  // position and emit flag follow the lane latency
  logic          emit_pipe_q [LANE_LAT];
  rwc_pkg::pos_t at_pipe_q   [LANE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LANE_LAT; s++) begin
        emit_pipe_q[s] <= 1'b0;
      end
    end else if (adv) begin
      emit_pipe_q[0] <= s2_emit_q;
      for (int s = 1; s < LANE_LAT; s++) begin
        emit_pipe_q[s] <= emit_pipe_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      at_pipe_q[0] <= s2_at_q;
      for (int s = 1; s < LANE_LAT; s++) begin
        at_pipe_q[s] <= at_pipe_q[s-1];
      end
    end
  end

  // ---------------------------------------------------------- merge, out
  rwc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_valid_i (emit_pipe_q[LANE_LAT-1]),
    .res_i       (lane_res),
    .pos_i       (at_pipe_q[LANE_LAT-1]),
    .adv_o       (adv),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[rtl/rwc_checker.sv]
// ----------------------------------------------------------------------------
// rwc_checker: port-level checks of the rgb window convolution
// output hold, ready behavior against output backpressure
// ----------------------------------------------------------------------------
`default_nettype none

module rwc_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [rwc_pkg::PIXEL_BITS-1:0]      out_red,
  input wire logic [rwc_pkg::OUT_ROW_BITS-1:0]    out_row,
  input wire logic [rwc_pkg::OUT_COL_BITS-1:0]    out_col
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_row)
      && $stable(out_col))
    else $error("result word changed while stalled");

  // an empty output register means the skid is empty too
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input held off with no result waiting");

  // input ready only falls after a result was held off
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input ready fell without output backpressure");

endmodule

bind rgb_window_convolution_5x5_top rwc_checker u_rwc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_red   (out_o.out_red),
  .out_row   (out_o.out_row),
  .out_col   (out_o.out_col)
);

`default_nettype wire

[tb/sv/rwc_conv_checker.sv]
// ----------------------------------------------------------------------------
// rwc_conv_checker: result checker of the rgb window convolution
// follows the register port and both word channels, predicts every result
// word and compares it field by field with what the block sends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwc_conv_checker
  import rwc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  rwc_in_if                      word_in,
  rwc_out_if                     word_out,
  output int unsigned            fail_count,
  output int unsigned            pending_count
);

  localparam int STORE_DEPTH = (KERNEL_SIZE - 1) * (MAX_WIDTH + 1) + 1;

  typedef struct packed {
    pix_t                    red;
    pix_t                    green;
    pix_t                    blue;
    logic [OUT_ROW_BITS-1:0] row;
    logic [OUT_COL_BITS-1:0] col;
    logic                    last;
  } filtered_t;

  filtered_t         filtered_q[$];
  rgb_coef_t         kernel[KTAPS];
  rgb_t              recent_pix[STORE_DEPTH];
  logic [CFG_W_BITS-1:0] width_reg;
  logic [CFG_H_BITS-1:0] height_reg;
  int unsigned       col_cnt;
  int unsigned       row_cnt;

  function automatic pix_t round_clip(logic [63:0] acc);
    logic [63:0] v;
    v = (acc + (64'd1 << (COEF_BITS - 1))) >> COEF_BITS;
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // one accepted input word: update state, queue the result it causes
  task automatic convolve_word(logic [FUNC_BITS-1:0] fn, logic [TAP_W-1:0] tap,
                               rgb_t pix, rgb_coef_t coef);
    int unsigned w, h, k, d, t, r, c, slot;
    int          pr, pc;
    logic [63:0] acc_r, acc_g, acc_b;
    filtered_t   res;
    if (fn == FUNC_LOAD) begin
      if (tap < KTAPS) kernel[tap] = coef;
      return;
    end
    if (fn != FUNC_PIXEL && fn != FUNC_FLUSH) return;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    k = row_cnt * w + col_cnt;
    recent_pix[k % STORE_DEPTH] = (fn == FUNC_PIXEL) ? pix : '0;
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    d = KHALF * w + KHALF;
    if (k < d) return;
    t = k - d;
    if (t >= w * h) begin
      col_cnt = 0;
      row_cnt = 0;
      return;
    end
    r = t / w;
    c = t % w;
    acc_r = '0;
    acc_g = '0;
    acc_b = '0;
    for (int m = 0; m < KERNEL_SIZE; m++) begin
      pr = int'(r) + m - KHALF;
      if (pr < 0 || pr >= int'(h)) continue;
      for (int n = 0; n < KERNEL_SIZE; n++) begin
        pc = int'(c) + n - KHALF;
        if (pc < 0 || pc >= int'(w)) continue;
        slot = (pr * w + pc) % STORE_DEPTH;
        acc_r += 64'(recent_pix[slot].red)   * 64'(kernel[m*KERNEL_SIZE+n].red);
        acc_g += 64'(recent_pix[slot].green) * 64'(kernel[m*KERNEL_SIZE+n].green);
        acc_b += 64'(recent_pix[slot].blue)  * 64'(kernel[m*KERNEL_SIZE+n].blue);
      end
    end
    res.red   = round_clip(acc_r);
    res.green = round_clip(acc_g);
    res.blue  = round_clip(acc_b);
    res.row   = r[OUT_ROW_BITS-1:0];
    res.col   = c[OUT_COL_BITS-1:0];
    res.last  = (t == w * h - 1);
    if (res.last) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    filtered_q = {filtered_q, res};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filtered_t   exp_w;
    int unsigned errs;
    if (!rst_ni) begin
      filtered_q.delete();
      for (int i = 0; i < KTAPS; i++) kernel[i] = '0;
      width_reg     = CFG_W_BITS'(WIDTH_RESET);
      height_reg    = CFG_H_BITS'(HEIGHT_RESET);
      col_cnt       = 0;
      row_cnt       = 0;
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      errs = 0;
      // result side first, a word accepted now cannot come out this edge
      if (word_out.valid && word_out.ready) begin
        if (filtered_q.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          exp_w = filtered_q.pop_front();
          if (word_out.out_red !== exp_w.red) begin
            $error("out_red expected %0d actual %0d", exp_w.red, word_out.out_red);
            errs++;
          end
          if (word_out.out_green !== exp_w.green) begin
            $error("out_green expected %0d actual %0d", exp_w.green, word_out.out_green);
            errs++;
          end
          if (word_out.out_blue !== exp_w.blue) begin
            $error("out_blue expected %0d actual %0d", exp_w.blue, word_out.out_blue);
            errs++;
          end
          if (word_out.out_row !== exp_w.row) begin
            $error("out_row expected %0d actual %0d", exp_w.row, word_out.out_row);
            errs++;
          end
          if (word_out.out_col !== exp_w.col) begin
            $error("out_col expected %0d actual %0d", exp_w.col, word_out.out_col);
            errs++;
          end
          if (word_out.last_of_frame !== exp_w.last) begin
            $error("last_of_frame expected %0d actual %0d", exp_w.last,
                   word_out.last_of_frame);
            errs++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WIDTH) width_reg = pwdata[CFG_W_BITS-1:0];
        else height_reg = pwdata[CFG_H_BITS-1:0];
        col_cnt = 0;
        row_cnt = 0;
      end
      if (word_in.valid && word_in.ready)
        convolve_word(word_in.func, word_in.tap_index,
                      '{word_in.pix_red, word_in.pix_green, word_in.pix_blue},
                      '{word_in.coef_red, word_in.coef_green, word_in.coef_blue});
      fail_count    <= fail_count + errs;
      pending_count <= filtered_q.size();
    end
  end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: top of the rgb window convolution test
// loads kernels, sets frame sizes over the register port and streams frames
// with random idling on both channels; the checker judges every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import rwc_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no handshake and no register access
  localparam int DRAIN_WAIT  = 16;    // pipeline depth is 7, leave margin

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int unsigned       fail_count;
  int unsigned       pending_count;
  int unsigned       quiet_cycles = 0;
  bit                steady = 1'b0;   // no idling on either side while set
  int unsigned       words_sent = 0;

  rwc_in_if  word_in ();
  rwc_out_if word_out ();

  rgb_window_convolution_5x5_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (word_in),
    .out_o   (word_out)
  );

  rwc_conv_checker checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .word_in       (word_in),
    .word_out      (word_out),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // known values on every input from time zero
  initial begin
    word_in.valid      = 1'b0;
    word_in.func       = FUNC_FLUSH;
    word_in.tap_index  = '0;
    word_in.pix_red    = '0;
    word_in.pix_green  = '0;
    word_in.pix_blue   = '0;
    word_in.coef_red   = '0;
    word_in.coef_green = '0;
    word_in.coef_blue  = '0;
    word_out.ready     = 1'b0;
  end

  // result side back-pressure, roughly a third of the cycles
  always @(posedge clk_i) begin
    word_out.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
  end

  // watchdog: no handshake and no register access for too long
  always @(posedge clk_i) begin
    if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // setup and access phase, written at the access edge
  task automatic reg_write(logic reg_idx, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one input word, random idle before it unless in a steady stretch
  task automatic send_word(func_e fn, logic [TAP_W-1:0] tap, rgb_t pix, rgb_coef_t coef);
    bit took;
    while (!steady && $urandom_range(0, 99) < 33) begin
      word_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    word_in.valid      <= 1'b1;
    word_in.func       <= fn;
    word_in.tap_index  <= tap;
    word_in.pix_red    <= pix.red;
    word_in.pix_green  <= pix.green;
    word_in.pix_blue   <= pix.blue;
    word_in.coef_red   <= coef.red;
    word_in.coef_green <= coef.green;
    word_in.coef_blue  <= coef.blue;
    do begin
      @(negedge clk_i);
      took = word_in.ready;
      @(posedge clk_i);
    end while (!took);
    words_sent++;
  endtask

  function automatic rgb_t rand_pix();
    rgb_t p;
    case ($urandom_range(0, 9))
      0:       p = '1;
      1:       p = '0;
      default: p = 48'({$urandom(), $urandom()});
    endcase
    return p;
  endfunction

  function automatic rgb_coef_t rand_coef();
    rgb_coef_t k;
    case ($urandom_range(0, 7))
      0:       k = '1;
      1:       k = '0;
      2:       k = {3{16'(1 << $urandom_range(0, 15))}};
      default: k = 48'({$urandom(), $urandom()} >> $urandom_range(0, 5));
    endcase
    return k;
  endfunction

  task automatic load_kernel(bit all_max);
    for (int i = 0; i < KTAPS; i++)
      send_word(FUNC_LOAD, TAP_W'(i), rand_pix(), all_max ? rgb_coef_t'('1) : rand_coef());
  endtask

  // occasional noise: unknown func, loads past the last tap, tap reloads
  task automatic maybe_noise();
    case ($urandom_range(0, 39))
      0: send_word(func_e'(2'd3), TAP_W'($urandom()), rand_pix(), rand_coef());
      1: send_word(FUNC_LOAD, TAP_W'($urandom_range(KTAPS, 31)), rand_pix(), rand_coef());
      2: send_word(FUNC_LOAD, TAP_W'($urandom_range(0, KTAPS - 1)), rand_pix(), rand_coef());
      default: ;
    endcase
  endtask

  // one whole frame of w x h (effective sizes) plus the drain words
  task automatic send_frame(int unsigned w, int unsigned h);
    for (int unsigned i = 0; i < w * h; i++) begin
      maybe_noise();
      if ($urandom_range(0, 9) == 0) send_word(FUNC_FLUSH, TAP_W'($urandom()), rand_pix(),
                                               rand_coef());
      else send_word(FUNC_PIXEL, TAP_W'($urandom()), rand_pix(), rand_coef());
    end
    for (int unsigned i = 0; i < 2 * w + 2; i++) begin
      maybe_noise();
      // a pixel word past the frame end acts as a flush
      send_word(($urandom_range(0, 3) == 0) ? FUNC_PIXEL : FUNC_FLUSH,
                TAP_W'($urandom()), rand_pix(), rand_coef());
    end
  endtask

  // idle point: every expected word is back and the pipe has emptied
  task automatic settle();
    word_in.valid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // sizes only change with the pipe empty
  task automatic set_size(int unsigned w, int unsigned h);
    settle();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  initial begin
    int unsigned w, h;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: saturating kernel on a tiny frame with extreme pixels
    set_size(3, 2);
    load_kernel(1'b1);
    send_word(FUNC_PIXEL, '0, '1, '0);
    send_word(FUNC_PIXEL, '1, '0, '1);
    send_word(func_e'(2'd3), '1, '1, '1);
    send_word(FUNC_LOAD, 5'd31, '0, '0);
    send_word(FUNC_FLUSH, '0, '1, '1);
    send_word(FUNC_PIXEL, '0, {16'h0001, 16'h8000, 16'hFFFF}, '0);
    send_word(FUNC_PIXEL, '0, '1, '0);
    send_word(FUNC_PIXEL, '0, '0, '0);
    for (int i = 0; i < 8; i++) send_word(FUNC_FLUSH, '0, '0, '0);
    settle();

    // single pixel frame, then sizes written as zero (act as one)
    load_kernel(1'b0);
    set_size(1, 1);
    send_frame(1, 1);
    settle();
    set_size(0, 0);
    send_frame(1, 1);
    settle();

    // longer frame with no idling on either side
    steady = 1'b1;
    set_size(16, 6);
    send_frame(16, 6);
    settle();
    steady = 1'b0;

    // random small frames, now and then a fresh kernel
    while (words_sent < 750) begin
      if ($urandom_range(0, 3) == 0) load_kernel(1'b0);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      steady = ($urandom_range(0, 5) == 0);
      set_size(w, h);
      repeat ($urandom_range(1, 2)) send_frame(w, h);
      settle();
    end
    steady = 1'b0;

    settle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[rgb_window_convolution_5x5_top.f]
rtl/rwc_pkg.sv
rtl/rwc_if.sv
rtl/rwc_line_buf.sv
rtl/rwc_lane.sv
rtl/rwc_merge.sv
rtl/rgb_window_convolution_5x5_top.sv
rtl/rwc_checker.sv
tb/sv/rwc_conv_checker.sv
tb/sv/testbench.sv
